// File: src/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared constants and codes for the RGB/HSV color converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int CHANNEL_BITS_DEF = 8;

    typedef enum logic [0:0] {
        DIR_RGB_TO_HSV = 1'b0,
        DIR_HSV_TO_RGB = 1'b1
    } direction_t;

    typedef enum logic [2:0] {
        SEC_RED_UP   = 3'd0,
        SEC_GRN_DOWN = 3'd1,
        SEC_GRN_UP   = 3'd2,
        SEC_BLU_DOWN = 3'd3,
        SEC_BLU_UP   = 3'd4,
        SEC_RED_DOWN = 3'd5
    } sector_t;

endpackage

// File: src/rgbhsv_front.sv
// ----------------------------------------------------------------------------
// rgbhsv_front
// Accepts pixels, classifies them and builds the three-lane division job.
// ----------------------------------------------------------------------------
module rgbhsv_front #(
    parameter int W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        direction,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [W-1:0]                first_channel,
    input  logic [W-1:0]                second_channel,
    input  logic [W-1:0]                third_channel,
    output logic                        job_valid,
    input  logic                        job_ready,
    output logic [3*(3*W+6)+W+4:0]      job_data
);
    import rgbhsv_pkg::*;

    localparam int RW = W + 3;
    localparam int LW = 2 * RW + W;
    localparam int EW = 3 * LW + W + 5;
    localparam logic [W-1:0]   FS = {W{1'b1}};
    localparam logic [2*W-1:0] PF = {FS, {W{1'b0}}};

    // Stage A: classification.
    logic              a_valid_reg;
    logic              a_dir_reg;
    logic              a_grey_reg;
    logic [W-1:0]      a_v_reg;
    logic [2:0]        a_sec_reg;
    logic [W-1:0]      a_delta_reg;
    logic [W-1:0]      a_mx_reg;
    logic [RW-1:0]     a_n_reg;
    logic [RW-1:0]     a_d6_reg;
    logic [W-1:0]      a_fs_reg;
    logic [2*W-1:0]    a_sf_reg;
    logic [2*W-1:0]    a_stf_reg;
    logic              a_ready;

    // Stage B: products, packed into one job.
    logic              b_valid_reg;
    logic [EW-1:0]     b_entry_reg;
    logic              b_ready;

    logic [W-1:0]      mx, mn, delta;
    logic signed [W+3:0] rs, gs, bs, d2s, d4s, d6s, n_raw, n_fix;
    logic [RW-1:0]     d6;
    logic [W+2:0]      h6;
    logic [W-1:0]      frac;
    logic [W:0]        omf;
    logic [2*W-1:0]    sf;
    logic [2*W+1:0]    stf_full;
    logic              grey;

    assign b_ready  = !b_valid_reg || job_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        mx = first_channel;
        mn = first_channel;
        if (second_channel > mx) mx = second_channel;
        if (third_channel > mx)  mx = third_channel;
        if (second_channel < mn) mn = second_channel;
        if (third_channel < mn)  mn = third_channel;
        delta = mx - mn;
        rs  = $signed({4'b0, first_channel});
        gs  = $signed({4'b0, second_channel});
        bs  = $signed({4'b0, third_channel});
        d2s = $signed({3'b0, delta, 1'b0});
        d4s = $signed({2'b0, delta, 2'b0});
        d6s = d2s + d4s;
        d6  = d6s[RW-1:0];
        // Red wins ties over green, green over blue.
        if (first_channel == mx)
            n_raw = gs - bs;
        else if (second_channel == mx)
            n_raw = d2s + bs - rs;
        else
            n_raw = d4s + rs - gs;
        n_fix = (n_raw < 0) ? (n_raw + d6s) : n_raw;

        h6   = {first_channel, 2'b0} + {1'b0, first_channel, 1'b0};
        frac = h6[W-1:0];
        omf  = {1'b1, {W{1'b0}}} - {1'b0, frac};
        sf   = second_channel * frac;
        stf_full = {1'b0, second_channel} * omf;

        if (direction == DIR_HSV_TO_RGB)
            grey = (second_channel == '0);
        else
            grey = (delta == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_dir_reg   <= direction;
            a_grey_reg  <= grey;
            a_v_reg     <= (direction == DIR_HSV_TO_RGB) ? third_channel : mx;
            a_sec_reg   <= h6[W+2:W];
            a_delta_reg <= delta;
            a_mx_reg    <= mx;
            a_n_reg     <= n_fix[RW-1:0];
            a_d6_reg    <= d6;
            a_fs_reg    <= FS - second_channel;
            a_sf_reg    <= sf;
            a_stf_reg   <= stf_full[2*W-1:0];
        end
    end

    logic [2*W-1:0] dfs, vfs, qm, tm;
    logic [3*W-1:0] yq, yt;
    logic [LW-1:0]  lane0, lane1, lane2;

    always_comb
    begin
        dfs = {a_delta_reg, {W{1'b0}}} - {{W{1'b0}}, a_delta_reg};
        vfs = a_v_reg * a_fs_reg;
        qm  = PF - a_sf_reg;
        tm  = PF - a_stf_reg;
        yq  = a_v_reg * qm;
        yt  = a_v_reg * tm;
        if (a_dir_reg == DIR_HSV_TO_RGB)
        begin
            lane0 = {3'b0, vfs[2*W-1:W], vfs[W-1:0], 3'b0, FS};
            lane1 = {3'b0, yq[3*W-1:2*W], yq[2*W-1:W], 3'b0, FS};
            lane2 = {3'b0, yt[3*W-1:2*W], yt[2*W-1:W], 3'b0, FS};
        end
        else
        begin
            lane0 = {3'b0, dfs[2*W-1:W], dfs[W-1:0], 3'b0, a_mx_reg};
            lane1 = {a_n_reg, {W{1'b0}}, a_d6_reg};
            lane2 = {{(2*RW+W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_entry_reg <= {a_dir_reg, a_grey_reg, a_v_reg, a_sec_reg, lane2, lane1, lane0};
        end
    end

    assign job_valid = b_valid_reg;
    assign job_data  = b_entry_reg;

endmodule

// File: src/rgbhsv_fifo.sv
// ----------------------------------------------------------------------------
// rgbhsv_fifo
// Two-entry queue that decouples the front end from the divider pipeline.
// ----------------------------------------------------------------------------
module rgbhsv_fifo #(
    parameter int EW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  logic [EW-1:0] wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output logic [EW-1:0] rd_data
);
    import rgbhsv_pkg::*;

    logic [EW-1:0] mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: src/rgbhsv_back.sv
// ----------------------------------------------------------------------------
// rgbhsv_back
// Three-lane restoring divider pipeline, one quotient bit per stage, with
// the final channel selection and the output register.
// ----------------------------------------------------------------------------
module rgbhsv_back #(
    parameter int W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    output logic                        job_ready,
    input  logic [3*(3*W+6)+W+4:0]      job_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [W-1:0]                out_first,
    output logic [W-1:0]                out_second,
    output logic [W-1:0]                out_third
);
    import rgbhsv_pkg::*;

    localparam int RW = W + 3;
    localparam int LW = 2 * RW + W;

    logic          en;

    logic [RW-1:0] rem_src [0:W-1][3];
    logic [W-1:0]  lo_src  [0:W-1][3];
    logic [W-1:0]  quo_src [0:W-1][3];
    logic [RW-1:0] div_src [0:W-1][3];
    logic          vld_src [0:W-1];
    logic          dir_src [0:W-1];
    logic          grey_src[0:W-1];
    logic [W-1:0]  v_src   [0:W-1];
    logic [2:0]    sec_src [0:W-1];

    logic [RW-1:0] rem_reg [1:W][3];
    logic [W-1:0]  lo_reg  [1:W][3];
    logic [W-1:0]  quo_reg [1:W][3];
    logic [RW-1:0] div_reg [1:W][3];
    logic          vld_reg [1:W];
    logic          dir_reg [1:W];
    logic          grey_reg[1:W];
    logic [W-1:0]  v_reg   [1:W];
    logic [2:0]    sec_reg [1:W];

    logic          out_valid_reg;
    logic [W-1:0]  out_first_reg, out_second_reg, out_third_reg;

    // The whole pipeline advances together whenever the output can move.
    assign en        = !out_valid_reg || out_ready;
    assign job_ready = en;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            div_src[0][l] = job_data[l*LW +: RW];
            lo_src[0][l]  = job_data[l*LW+RW +: W];
            rem_src[0][l] = job_data[l*LW+RW+W +: RW];
            quo_src[0][l] = '0;
        end
        vld_src[0]  = job_valid;
        sec_src[0]  = job_data[3*LW +: 3];
        v_src[0]    = job_data[3*LW+3 +: W];
        grey_src[0] = job_data[3*LW+3+W];
        dir_src[0]  = job_data[3*LW+4+W];
        for (int k = 1; k < W; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                div_src[k][l] = div_reg[k][l];
                lo_src[k][l]  = lo_reg[k][l];
                rem_src[k][l] = rem_reg[k][l];
                quo_src[k][l] = quo_reg[k][l];
            end
            vld_src[k]  = vld_reg[k];
            sec_src[k]  = sec_reg[k];
            v_src[k]    = v_reg[k];
            grey_src[k] = grey_reg[k];
            dir_src[k]  = dir_reg[k];
        end
    end

    genvar gk, gl;
    generate
        for (gk = 0; gk < W; gk++)
        begin : g_stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[gk+1] <= 1'b0;
                else if (en)
                    vld_reg[gk+1] <= vld_src[gk];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dir_reg[gk+1]  <= dir_src[gk];
                    grey_reg[gk+1] <= grey_src[gk];
                    v_reg[gk+1]    <= v_src[gk];
                    sec_reg[gk+1]  <= sec_src[gk];
                end
            end

            for (gl = 0; gl < 3; gl++)
            begin : g_lane
                logic [RW:0] trial;
                logic [RW:0] diff;
                logic        ge;

                assign trial = {rem_src[gk][gl], lo_src[gk][gl][W-1]};
                assign ge    = (trial >= {1'b0, div_src[gk][gl]});
                assign diff  = trial - {1'b0, div_src[gk][gl]};

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[gk+1][gl] <= ge ? diff[RW-1:0] : trial[RW-1:0];
                        lo_reg[gk+1][gl]  <= {lo_src[gk][gl][W-2:0], 1'b0};
                        quo_reg[gk+1][gl] <= {quo_src[gk][gl][W-2:0], ge};
                        div_reg[gk+1][gl] <= div_src[gk][gl];
                    end
                end
            end
        end
    endgenerate

    logic [W-1:0] o1, o2, o3, pq, qq, tq, vv;

    always_comb
    begin
        vv = v_reg[W];
        pq = quo_reg[W][0];
        qq = quo_reg[W][1];
        tq = quo_reg[W][2];
        if (dir_reg[W] == DIR_RGB_TO_HSV)
        begin
            o1 = grey_reg[W] ? '0 : qq;
            o2 = grey_reg[W] ? '0 : pq;
            o3 = vv;
        end
        else if (grey_reg[W])
        begin
            o1 = vv;
            o2 = vv;
            o3 = vv;
        end
        else
        begin
            case (sec_reg[W])
                SEC_RED_UP:   begin o1 = vv; o2 = tq; o3 = pq; end
                SEC_GRN_DOWN: begin o1 = qq; o2 = vv; o3 = pq; end
                SEC_GRN_UP:   begin o1 = pq; o2 = vv; o3 = tq; end
                SEC_BLU_DOWN: begin o1 = pq; o2 = qq; o3 = vv; end
                SEC_BLU_UP:   begin o1 = tq; o2 = pq; o3 = vv; end
                default:      begin o1 = vv; o2 = pq; o3 = qq; end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[W];
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[W])
        begin
            out_first_reg  <= o1;
            out_second_reg <= o2;
            out_third_reg  <= o3;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign out_third  = out_third_reg;

endmodule

// File: src/rgb_hsv_color_convert_top.sv
// ----------------------------------------------------------------------------
// rgb_hsv_color_convert_top
// Streaming per-pixel converter between RGB and HSV color spaces.
// ----------------------------------------------------------------------------
// Pixels arrive on the input channel (in_valid/in_ready) with three channel
// fields and leave on the output channel (out_valid/out_ready). Each input
// transaction yields exactly one output transaction, in order.
// The direction register is loaded through the configuration channel
// (cfg_valid/cfg_ready/cfg_data). It is always ready; bit 0 of the data
// selects RGB to HSV (0) or HSV to RGB (1). Write it only while idle.
// Throughput is one pixel per clock while nothing stalls. An accepted pixel
// passes in order through the first front stage, which loads on the edge
// that accepts it, the second front stage and the queue write, then one
// divider stage per quotient bit of the three-lane restoring divider, and
// finally the output register. The divider depth is what sets the latency.
// Reset (rst_n low, asynchronous) clears all valid flags and the queue and
// returns the direction to RGB to HSV.
// When the receiver stalls, the divider pipeline freezes behind the output
// register; the two-entry queue and the front stages keep accepting until
// they fill, then in_ready drops.
// ----------------------------------------------------------------------------
module rgb_hsv_color_convert_top #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CHANNEL_BITS-1:0] first_channel,
    input  logic [CHANNEL_BITS-1:0] second_channel,
    input  logic [CHANNEL_BITS-1:0] third_channel,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHANNEL_BITS-1:0] out_first,
    output logic [CHANNEL_BITS-1:0] out_second,
    output logic [CHANNEL_BITS-1:0] out_third
);
    import rgbhsv_pkg::*;

    localparam int W  = CHANNEL_BITS;
    localparam int EW = 3 * (3 * W + 6) + W + 5;

    logic          direction_reg;
    logic          job_valid, job_ready;
    logic [EW-1:0] job_data;
    logic          q_valid, q_ready;
    logic [EW-1:0] q_data;

    // Configuration is a single register and never backpressures.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            direction_reg <= DIR_RGB_TO_HSV;
        else if (cfg_valid && cfg_ready)
            direction_reg <= cfg_data;
    end

    // Front end: max/min, sector and the products that feed the dividers.
    rgbhsv_front #(.W(W)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .direction      (direction_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first_channel  (first_channel),
        .second_channel (second_channel),
        .third_channel  (third_channel),
        .job_valid      (job_valid),
        .job_ready      (job_ready),
        .job_data       (job_data)
    );

    // Short queue so the front end and the divider stall independently.
    rgbhsv_fifo #(.EW(EW)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (job_valid),
        .wr_ready (job_ready),
        .wr_data  (job_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    // Back end: division pipeline and channel selection.
    rgbhsv_back #(.W(W)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (q_valid),
        .job_ready  (q_ready),
        .job_data   (q_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_first  (out_first),
        .out_second (out_second),
        .out_third  (out_third)
    );

endmodule

// File: src/rgbhsv_checker.sv
// ----------------------------------------------------------------------------
// rgbhsv_checker
// Port-level checks for the RGB/HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rgbhsv_checker #(
    parameter int W = 8
) (
    input logic         clk,
    input logic         rst_n,
    input logic         cfg_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [W-1:0] out_first,
    input logic [W-1:0] out_second,
    input logic [W-1:0] out_third
);
    import rgbhsv_pkg::*;

    // A stalled result transaction stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(out_first) && $stable(out_second) && $stable(out_third))
        else $error("output payload changed while stalled");

    // Reset clears the output valid flag.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    // Results do not reach the output in the cycle after reset releases.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("out_valid high right after reset");

    // The configuration register never backpressures.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready low");

endmodule

bind rgb_hsv_color_convert_top rgbhsv_checker #(.W(CHANNEL_BITS)) u_rgbhsv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ready  (cfg_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_first  (out_first),
    .out_second (out_second),
    .out_third  (out_third)
);
